// File: design/midi_track_event_encoder_defines.svh
// Assertion macros shared by the MIDI track event encoder.
`ifndef MIDI_TRACK_EVENT_ENCODER_DEFINES_SVH
`define MIDI_TRACK_EVENT_ENCODER_DEFINES_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define MTE_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Checks that the consequent holds in the cycle after the antecedent.
`define MTE_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: design/mte_pkg.sv
// Types, constants and helper functions of the MIDI track event encoder.
package mte_pkg;

    typedef struct packed {
        logic        command;
        logic [31:0] delta_time;
        logic [7:0]  status;
        logic [6:0]  data_first;
        logic [6:0]  data_second;
    } t_req;

    typedef struct packed {
        logic [7:0]  out_byte;
        logic        last;
        logic [31:0] track_length;
    } t_rsp;

    localparam logic        CMD_END_OF_TRACK = 1'b1;
    localparam logic [31:0] SCALE_RESET      = 32'h0001_0000;
    localparam logic [63:0] ROUND_HALF       = 64'h0000_0000_0000_8000;
    localparam logic [27:0] VLQ_MAX          = 28'hFFF_FFFF;
    localparam logic [7:0]  STATUS_MSB       = 8'h80;
    localparam logic [7:0]  SYSTEM_BASE      = 8'hF0;

    function automatic logic [7:0] eot_byte(input logic [1:0] idx);
        logic [7:0] b;
        unique case (idx)
            2'd0:    b = 8'h00;
            2'd1:    b = 8'hFF;
            2'd2:    b = 8'h2F;
            default: b = 8'h00;
        endcase
        return b;
    endfunction

    function automatic logic [1:0] data_count(input logic [7:0] st);
        logic [1:0] n;
        case (st[7:4]) inside
            4'hC, 4'hD: n = 2'd1;
            4'hF: begin
                case (st[3:0]) inside
                    4'h1, 4'h3: n = 2'd1;
                    4'h2:       n = 2'd2;
                    default:    n = 2'd0;
                endcase
            end
            default: n = 2'd2;
        endcase
        return n;
    endfunction

endpackage

// File: design/midi_track_event_encoder.sv
// MIDI track event encoder: scales delta times and emits the track byte stream.
// An event request is taken only while the block is idle. Its delta time is
// scaled by a bit-serial shift-add multiplier, a rounding step then rounds
// and saturates the result, and then one stream byte leaves per cycle
// while the output is free: the delta time as one to four length groups, the
// status byte unless running status covers it, and up to two data bytes. An
// event emits two to seven stream bytes; an end-of-track request emits four.
`include "midi_track_event_encoder_defines.svh"

module midi_track_event_encoder (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cfg_we,
    input  logic [31:0]   i_cfg_wdata,
    input  logic          i_req_valid,
    output logic          o_req_ready,
    input  mte_pkg::t_req i_req,
    output logic          o_rsp_valid,
    input  logic          i_rsp_ready,
    output mte_pkg::t_rsp o_rsp
);
    import mte_pkg::*;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_MUL  = 3'd1;
    localparam logic [2:0] ST_RND  = 3'd2;
    localparam logic [2:0] ST_VLQ  = 3'd3;
    localparam logic [2:0] ST_STAT = 3'd4;
    localparam logic [2:0] ST_D1   = 3'd5;
    localparam logic [2:0] ST_D2   = 3'd6;
    localparam logic [2:0] ST_EOT  = 3'd7;

    logic [2:0]  r_state, n_state;
    logic [31:0] r_scale, n_scale;
    logic [7:0]  r_run, n_run;
    logic [31:0] r_count, n_count;
    logic        r_o_valid, n_o_valid;
    logic [63:0] r_acc, n_acc;
    logic [31:0] r_mul, n_mul;
    logic [4:0]  r_bit, n_bit;
    logic [27:0] r_ticks, n_ticks;
    logic [1:0]  r_grp, n_grp;
    logic        r_send_st, n_send_st;
    logic [1:0]  r_ndata, n_ndata;
    logic [7:0]  r_st, n_st;
    logic [6:0]  r_d1, n_d1;
    logic [6:0]  r_d2, n_d2;
    t_rsp        r_out, n_out;

    logic        w_take;
    logic        w_emit;
    logic        w_load;
    logic        w_last;
    logic [2:0]  w_after;
    logic [7:0]  w_byte;
    logic [7:0]  w_status;
    logic [32:0] w_sum;
    logic [63:0] w_rnd;
    logic [27:0] w_ticks;

    assign o_req_ready = (r_state == ST_IDLE);
    assign o_rsp_valid = r_o_valid;
    assign o_rsp       = r_out;

    assign w_take   = i_req_valid && (r_state == ST_IDLE);
    assign w_emit   = (r_state == ST_VLQ) || (r_state == ST_STAT) || (r_state == ST_D1)
                   || (r_state == ST_D2) || (r_state == ST_EOT);
    assign w_load   = w_emit && (!r_o_valid || i_rsp_ready);
    assign w_last   = (w_after == ST_IDLE);
    assign w_status = i_req.status | STATUS_MSB;
    assign w_sum    = {1'b0, r_acc[63:32]} + (r_mul[0] ? {1'b0, r_scale} : 33'd0);
    assign w_rnd    = r_acc + ROUND_HALF;
    assign w_ticks  = (|w_rnd[63:44]) ? VLQ_MAX : w_rnd[43:16];

    always_comb begin
        n_state   = r_state;
        n_scale   = i_cfg_we ? i_cfg_wdata : r_scale;
        n_run     = r_run;
        n_count   = r_count;
        n_o_valid = r_o_valid;
        n_acc     = r_acc;
        n_mul     = r_mul;
        n_bit     = r_bit;
        n_ticks   = r_ticks;
        n_grp     = r_grp;
        n_send_st = r_send_st;
        n_ndata   = r_ndata;
        n_st      = r_st;
        n_d1      = r_d1;
        n_d2      = r_d2;
        n_out     = r_out;
        w_after   = r_state;
        w_byte    = 8'h00;

        unique case (r_state)
            ST_IDLE: begin
                if (w_take) begin
                    if (i_req.command == CMD_END_OF_TRACK) begin
                        n_state = ST_EOT;
                        n_grp   = 2'd0;
                        n_run   = 8'h00;
                    end else begin
                        n_state   = ST_MUL;
                        n_acc     = 64'd0;
                        n_mul     = i_req.delta_time;
                        n_bit     = 5'd0;
                        n_st      = w_status;
                        n_d1      = i_req.data_first;
                        n_d2      = i_req.data_second;
                        n_ndata   = data_count(w_status);
                        n_send_st = (w_status >= SYSTEM_BASE) || (w_status != r_run);
                        n_run     = (w_status >= SYSTEM_BASE) ? 8'h00 : w_status;
                    end
                end
            end
            ST_MUL: begin
                n_acc = {w_sum, r_acc[31:1]};
                n_mul = r_mul >> 1;
                n_bit = r_bit + 5'd1;
                if (r_bit == 5'd31) begin
                    n_state = ST_RND;
                end
            end
            ST_RND: begin
                n_state = ST_VLQ;
                if (w_ticks[27:21] != 7'd0) begin
                    n_grp   = 2'd3;
                    n_ticks = w_ticks;
                end else if (w_ticks[20:14] != 7'd0) begin
                    n_grp   = 2'd2;
                    n_ticks = {w_ticks[20:0], 7'd0};
                end else if (w_ticks[13:7] != 7'd0) begin
                    n_grp   = 2'd1;
                    n_ticks = {w_ticks[13:0], 14'd0};
                end else begin
                    n_grp   = 2'd0;
                    n_ticks = {w_ticks[6:0], 21'd0};
                end
            end
            ST_VLQ: begin
                w_byte = {(r_grp != 2'd0), r_ticks[27:21]};
                if (r_grp != 2'd0) begin
                    w_after = ST_VLQ;
                end else if (r_send_st) begin
                    w_after = ST_STAT;
                end else if (r_ndata != 2'd0) begin
                    w_after = ST_D1;
                end else begin
                    w_after = ST_IDLE;
                end
                if (w_load) begin
                    n_ticks = {r_ticks[20:0], 7'd0};
                    n_grp   = r_grp - 2'd1;
                end
            end
            ST_STAT: begin
                w_byte  = r_st;
                w_after = (r_ndata != 2'd0) ? ST_D1 : ST_IDLE;
            end
            ST_D1: begin
                w_byte  = {1'b0, r_d1};
                w_after = (r_ndata == 2'd2) ? ST_D2 : ST_IDLE;
            end
            ST_D2: begin
                w_byte  = {1'b0, r_d2};
                w_after = ST_IDLE;
            end
            ST_EOT: begin
                w_byte  = eot_byte(r_grp);
                w_after = (r_grp == 2'd3) ? ST_IDLE : ST_EOT;
                if (w_load) begin
                    n_grp = r_grp + 2'd1;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase

        if (w_load) begin
            n_state            = w_after;
            n_o_valid          = 1'b1;
            n_out.out_byte     = w_byte;
            n_out.last         = w_last;
            n_out.track_length = r_count + 32'd1;
            n_count            = (r_state == ST_EOT && w_last) ? 32'd0 : r_count + 32'd1;
        end else if (i_rsp_ready) begin
            n_o_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_scale   <= SCALE_RESET;
            r_run     <= 8'h00;
            r_count   <= 32'd0;
            r_o_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_scale   <= n_scale;
            r_run     <= n_run;
            r_count   <= n_count;
            r_o_valid <= n_o_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_acc     <= n_acc;
        r_mul     <= n_mul;
        r_bit     <= n_bit;
        r_ticks   <= n_ticks;
        r_grp     <= n_grp;
        r_send_st <= n_send_st;
        r_ndata   <= n_ndata;
        r_st      <= n_st;
        r_d1      <= n_d1;
        r_d2      <= n_d2;
        r_out     <= n_out;
    end

    `MTE_ASSERT_NEXT(a_take_starts_work, i_clk, i_rst_n, w_take,
        (r_state == ST_MUL) || (r_state == ST_EOT), "Accepted request did not start work.")
    `MTE_ASSERT_NEXT(a_mul_ends_in_round, i_clk, i_rst_n,
        (r_state == ST_MUL) && (r_bit == 5'd31), r_state == ST_RND,
        "Multiplier did not hand over to rounding.")
    `MTE_ASSERT_NEXT(a_last_returns_idle, i_clk, i_rst_n, w_load && w_last,
        (r_state == ST_IDLE) && o_rsp.last, "Final byte did not return the block to idle.")
    `MTE_ASSERT_SAME(a_busy_not_ready, i_clk, i_rst_n, w_emit || (r_state == ST_MUL),
        !o_req_ready, "Request port open while an event is in progress.")

endmodule
